// File: hdl/keyed_cache_lru_random_assert.svh
// Assertion macros shared by the cache RTL.
// Include guard keeps one definition per compilation unit.
`ifndef KEYED_CACHE_LRU_RANDOM_ASSERT_SVH
`define KEYED_CACHE_LRU_RANDOM_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define KC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("keyed cache check failed");
// Next-cycle implication outside reset.
`define KC_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("keyed cache check failed");
`endif

// File: hdl/kc_pkg.sv
// Package for the keyed cache: op codes, state encoding, LFSR step.
// No dependencies.
`default_nettype none
package kc_pkg;
    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;
    localparam logic       POL_LRU = 1'b0;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam int KEY_BITS = 64;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_DONE = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        lfsr_next = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction
endpackage
`default_nettype wire

// File: hdl/kc_ram.sv
// Generic single-port-write RAM with one registered read port.
// No dependencies.
`default_nettype none
module kc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/keyed_cache_lru_random.sv
// Keyed cache top level: tag/rank cells, data RAM and operation sequencer.
// Depends on kc_pkg, kc_ram and keyed_cache_lru_random_assert.svh.
//
//  channel | signals                               | direction
//  in      | i_valid/o_ready, i_op i_id i_payload  | to block
//  out     | o_valid/i_ready, o_found .. o_occupancy| from block
//  cfg     | i_cfg_we, i_cfg_data                  | to block
//
// An item passes through the states in order: accept in idle, tag
// compare and cell update with the data RAM read of the matched
// slot, the result word capture, then the result held until taken.
// Reset (synchronous, active low) clears valid bits, ranks, counters; loads the LFSR seed.
// A stalled output holds the result and blocks the next word.
// The random victim rank is prepared from the LFSR via the registered quotient r_quo, then remainder r_rnd.
`default_nettype none
`include "keyed_cache_lru_random_assert.svh"
module keyed_cache_lru_random
    import kc_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_id,
    input  wire logic [31:0] i_payload,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [31:0]      o_data,
    output logic             o_evicted,
    output logic [63:0]      o_evicted_key,
    output logic [31:0]      o_hits,
    output logic [31:0]      o_misses,
    output logic [4:0]       o_occupancy
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] OLDEST = IW'(ENTRIES - 1);
    localparam int RS = 16 + $clog2(ENTRIES + 1);
    localparam int RM_INT = ((1 << RS) + ENTRIES) / (ENTRIES + 1);
    localparam logic [17:0] RM = 18'(RM_INT);

    t_state r_state, n_state;
    logic              r_policy;
    logic [ENTRIES-1:0] r_vld;
    logic [IW-1:0]     r_rank [ENTRIES];
    logic [KEY_BITS-1:0] r_key [ENTRIES];
    logic [CW-1:0]     r_fill;
    logic [31:0]       r_hits, r_misses;
    logic [15:0]       r_lfsr;
    logic [15:0]       r_quo;
    logic [IW:0]       r_rnd;
    logic [1:0]        r_op;
    logic [63:0]       r_id;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic              r_found;
    logic              r_found_q;

    // result registers
    logic              r_ovld, r_ofound, r_oev;
    logic [31:0]       r_odata;
    logic [63:0]       r_oekey;

    // compare all key cells against the held id
    logic [ENTRIES-1:0] hit_vec;
    logic               hit_any;
    logic [IW-1:0]      hit_idx;
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            hit_vec[i] = r_vld[i] && (r_key[i] == r_id);
            if (hit_vec[i]) hit_idx = IW'(i);
        end
        hit_any = |hit_vec;
    end

    // data RAM: read at matched slot, written on add
    logic              ram_we;
    logic [IW-1:0]     ram_wa;
    logic [PAYLOAD_BITS-1:0] ram_rd;
    kc_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_data (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(r_pay),
        .i_raddr(hit_idx), .o_rdata(ram_rd)
    );

    // LFSR remainder by reciprocal multiplication, quotient then remainder
    logic [33:0] rnd_prod;
    logic [24:0] rnd_qd;
    logic [24:0] rnd_rem;
    assign rnd_prod = {18'd0, r_lfsr} * {16'd0, RM};
    assign rnd_qd   = {9'd0, r_quo} * 25'(ENTRIES + 1);
    assign rnd_rem  = {9'd0, r_lfsr} - rnd_qd;

    // pick the first free slot and the victim
    logic [IW-1:0] free_idx;
    logic [IW:0]   rnd_r;
    logic          self_ev;
    logic [IW-1:0] vic_rank;
    logic [IW-1:0] vic_idx;
    logic          vic_ok;
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_vld[i]) free_idx = IW'(i);
        end
        rnd_r    = r_rnd;
        self_ev  = (r_policy != POL_LRU) && (rnd_r == '0);
        vic_rank = (r_policy == POL_LRU) ? OLDEST : IW'(rnd_r - 1'b1);
        vic_idx  = '0;
        vic_ok   = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_vld[i] && r_rank[i] == vic_rank) begin
                vic_idx = IW'(i);
                vic_ok  = 1'b1;
            end
        end
    end

    wire do_in  = i_valid && o_ready;
    wire full   = (r_fill == CW'(ENTRIES));
    wire is_add = (r_op == OP_ADD);
    wire ins_new = (r_state == ST_LOOK) && is_add && !hit_any;

    assign ram_we = (r_state == ST_LOOK) && is_add &&
                    (hit_any || !full || (!self_ev && vic_ok));
    assign ram_wa = hit_any ? hit_idx : (!full ? free_idx : vic_idx);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (do_in) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_DONE;
            ST_DONE: n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    // capture the word, update cells, counters and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_policy <= 1'b0;
            r_vld    <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
            r_fill   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_lfsr   <= LFSR_SEED;
            r_quo    <= 16'(int'(LFSR_SEED) / (ENTRIES + 1));
            r_rnd    <= (IW + 1)'(int'(LFSR_SEED) % (ENTRIES + 1));
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_quo   <= 16'(rnd_prod >> RS);
            r_rnd   <= rnd_rem[IW:0];
            if (i_cfg_we) r_policy <= i_cfg_data;
            if (do_in) begin
                r_op  <= i_op;
                r_id  <= i_id;
                r_pay <= PAYLOAD_BITS'(i_payload);
            end
            if (r_state == ST_LOOK) begin
                r_found <= hit_any && (r_op != 2'd3);
                r_oev   <= ins_new && full && (self_ev || vic_ok);
                r_oekey <= !(ins_new && full) ? '0 :
                           self_ev ? r_id : vic_ok ? r_key[vic_idx] : '0;
                priority if (hit_any && (r_op == OP_GET || is_add)) begin
                    if (r_op == OP_GET) r_hits <= r_hits + 32'd1;
                    if (r_policy == POL_LRU) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (r_vld[i] && r_rank[i] < r_rank[hit_idx])
                                r_rank[i] <= r_rank[i] + 1'b1;
                        r_rank[hit_idx] <= '0;
                    end
                end else if (r_op == OP_GET) begin
                    r_misses <= r_misses + 32'd1;
                end else if (hit_any && r_op == OP_REM) begin
                    r_vld[hit_idx] <= 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_vld[i] && r_rank[i] > r_rank[hit_idx])
                            r_rank[i] <= r_rank[i] - 1'b1;
                    r_fill <= r_fill - 1'b1;
                end else if (ins_new && !full) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_vld[i]) r_rank[i] <= r_rank[i] + 1'b1;
                    r_vld[free_idx]  <= 1'b1;
                    r_key[free_idx]  <= r_id;
                    r_rank[free_idx] <= '0;
                    r_fill <= r_fill + 1'b1;
                end else if (ins_new) begin
                    if (r_policy != POL_LRU) r_lfsr <= lfsr_next(r_lfsr);
                    if (!self_ev && vic_ok) begin
                        // drop victim then insert at front
                        for (int i = 0; i < ENTRIES; i++)
                            if (r_vld[i] && r_rank[i] < vic_rank)
                                r_rank[i] <= r_rank[i] + 1'b1;
                        r_key[vic_idx]  <= r_id;
                        r_rank[vic_idx] <= '0;
                    end
                end else begin
                end
            end
            if (r_state == ST_DONE) begin
                r_ovld   <= 1'b1;
                r_ofound <= r_found;
                r_odata  <= (r_found && r_op == OP_GET) ? 32'(ram_rd) : 32'd0;
            end
            if (r_state == ST_OUT && i_ready) r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) r_found_q <= r_found;

    assign o_valid       = r_ovld;
    assign o_found       = r_ofound;
    assign o_data        = r_odata;
    assign o_evicted     = r_oev;
    assign o_evicted_key = r_oekey;
    assign o_hits        = r_hits;
    assign o_misses      = r_misses;
    assign o_occupancy   = 5'(r_fill);

    `KC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(ENTRIES))
    `KC_ASSERT_IMP(a_fill_pop, i_clk, i_rst_n, 1'b1, $countones(r_vld) == 32'(r_fill))
    `KC_ASSERT_IMP(a_out_state, i_clk, i_rst_n, o_valid, r_state == ST_OUT)
    `KC_ASSERT_NXT(a_found_hold, i_clk, i_rst_n, r_state == ST_OUT, r_found_q == r_found)
endmodule
`default_nettype wire
